### sv/gpvc_pkg.sv
// package: types, constants and tables of the go-to-goal pose controller
package gpvc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CW                = 44;  // cordic x/y datapath width
  localparam int DW                = 43;  // distance width (q16 mm)
  localparam int PW                = CW + 21;
  localparam logic signed [20:0] INVK_Q20  = 21'sd636751;
  localparam logic signed [15:0] OMEGA_Q16 = 16'sd18850;

  typedef enum logic [2:0] {
    REG_GOAL_X        = 3'd0,
    REG_GOAL_Y        = 3'd1,
    REG_GOAL_HEADING  = 3'd2,
    REG_LINEAR_LIMIT  = 3'd3,
    REG_ANGULAR_LIMIT = 3'd4,
    REG_POS_TOL       = 3'd5,
    REG_HEAD_TOL      = 3'd6,
    REG_TIMEOUT       = 3'd7
  } reg_idx_t;

  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_REACHED = 2'd1;
  localparam logic [1:0] ST_ABORTED = 2'd2;

  typedef struct packed {
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] pose_heading;
    logic [31:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic [1:0]         nav_status;
  } out_item_t;

  // control travelling alongside the cordic data
  typedef struct packed {
    logic               valid;
    logic               tmo;
    logic               zero;
    logic               hok;
    logic               reached;
    logic [15:0]        ph;
    logic signed [15:0] om;
  } side_t;

  // atan(2^-i), full turn = 2^32
  function automatic logic [31:0] atan_ent(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // symmetric saturation to +-lim
  function automatic logic signed [15:0] sat16(input logic signed [30:0] v,
                                               input logic [14:0] lim);
    logic signed [30:0] l;
    logic signed [15:0] r;
    l = 31'(signed'({1'b0, lim}));
    if (v > l) r = 16'(l);
    else if (v < -l) r = 16'(-l);
    else r = 16'(v);
    return r;
  endfunction

endpackage

### sv/goto_pose_velocity_controller_core.sv
// top level: pipelined proportional go-to-goal pose controller
// usage
//  - input: drive in_data and raise start; a pose is taken at every edge with
//    start high and busy low. busy stays low, so a pose may enter every cycle
//  - result: one result per pose, on out_data for a single cycle with
//    out_valid high; the receiver cannot stall, each transfer is final
//  - stages: input, start vector, the vectoring cordic chain, distance
//    scale, rotating start, the rotating cordic chain, velocity scale and
//    output; each unrolled chain is one register per micro-rotation
//  - throughput: one pose per cycle, every stage is a plain register
//  - configuration: cfg_we writes cfg_wdata to register cfg_idx at once;
//    write only while no pose is in flight (not enforced by the block)
//  - reset (rst_n low, synchronous): valid bits cleared, configuration
//    registers back to their defaults; no clearing pass is needed
//  - timeout: elapsed_ms beyond timeout_ms gives aborted and zero velocities
module goto_pose_velocity_controller_core #(
  parameter int CORDIC_STAGES = gpvc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gpvc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output gpvc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata
);

  localparam int W  = gpvc_pkg::CW;
  localparam int N  = CORDIC_STAGES;
  localparam int ZR = 34;

  // configuration registers
  logic signed [23:0] goal_x_r, goal_y_r;
  logic signed [15:0] goal_h_r;
  logic [14:0]        lin_lim_r, ang_lim_r;
  logic [15:0]        pos_tol_r, head_tol_r;
  logic [31:0]        timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      goal_h_r   <= '0;
      lin_lim_r  <= 15'd500;
      ang_lim_r  <= 15'd1000;
      pos_tol_r  <= 16'd20;
      head_tol_r <= 16'd182;
      timeout_r  <= 32'd10000;
    end else if (cfg_we) begin
      case (gpvc_pkg::reg_idx_t'(cfg_idx))
        gpvc_pkg::REG_GOAL_X:        goal_x_r   <= cfg_wdata[23:0];
        gpvc_pkg::REG_GOAL_Y:        goal_y_r   <= cfg_wdata[23:0];
        gpvc_pkg::REG_GOAL_HEADING:  goal_h_r   <= cfg_wdata[15:0];
        gpvc_pkg::REG_LINEAR_LIMIT:  lin_lim_r  <= cfg_wdata[14:0];
        gpvc_pkg::REG_ANGULAR_LIMIT: ang_lim_r  <= cfg_wdata[14:0];
        gpvc_pkg::REG_POS_TOL:       pos_tol_r  <= cfg_wdata[15:0];
        gpvc_pkg::REG_HEAD_TOL:      head_tol_r <= cfg_wdata[15:0];
        gpvc_pkg::REG_TIMEOUT:       timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: goal offset, heading error and yaw product
  logic               s0_v_r, s0_tmo_r;
  logic signed [24:0] s0_dx_r, s0_dy_r;
  logic signed [15:0] s0_e_r;
  logic [15:0]        s0_ph_r;
  logic signed [31:0] s0_omp_r;
  logic signed [15:0] e_nxt;

  assign e_nxt = goal_h_r - in_data.pose_heading;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else        s0_v_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s0_tmo_r <= in_data.elapsed_ms > timeout_r;
    s0_dx_r  <= 25'(goal_x_r) - 25'(in_data.pose_x);
    s0_dy_r  <= 25'(goal_y_r) - 25'(in_data.pose_y);
    s0_e_r   <= e_nxt;
    s0_ph_r  <= in_data.pose_heading;
    s0_omp_r <= e_nxt * gpvc_pkg::OMEGA_Q16;
  end

  // stage 1: vectoring start vector, half-plane fold, yaw saturation
  logic signed [W-1:0]  vx [0:N];
  logic signed [W-1:0]  vy [0:N];
  logic signed [31:0]   vz [0:N];
  gpvc_pkg::side_t      sbv [0:N];

  logic signed [W-1:0] dxw, dyw;
  logic signed [31:0]  omr;
  logic signed [16:0]  ae;
  gpvc_pkg::side_t     sb1_nxt;

  always_comb begin
    dxw = W'(s0_dx_r) <<< 16;
    dyw = W'(s0_dy_r) <<< 16;
    omr = (s0_omp_r + 32'sd32768) >>> 16;
    ae  = s0_e_r[15] ? -17'(s0_e_r) : 17'(s0_e_r);
    sb1_nxt         = '0;
    sb1_nxt.valid   = s0_v_r;
    sb1_nxt.tmo     = s0_tmo_r;
    sb1_nxt.zero    = (s0_dx_r == '0) && (s0_dy_r == '0);
    sb1_nxt.hok     = ae < 17'({1'b0, head_tol_r});
    sb1_nxt.ph      = s0_ph_r;
    sb1_nxt.om      = gpvc_pkg::sat16(31'(omr), ang_lim_r);
  end

  always_ff @(posedge clk) begin
    if (dxw[W-1]) begin
      vx[0] <= -dxw;
      vy[0] <= -dyw;
      vz[0] <= 32'sh8000_0000;
    end else begin
      vx[0] <= dxw;
      vy[0] <= dyw;
      vz[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sbv[0] <= '0;
    else        sbv[0] <= sb1_nxt;
  end

  // vectoring chain: magnitude and bearing
  for (genvar k = 0; k < N; k++) begin : g_vec
    gpvc_cordic_stage #(.W(W), .WZ(32), .SHIFT(k), .VECTOR(1'b1)) u_stage (
      .clk (clk),
      .x_i (vx[k]), .y_i (vy[k]), .z_i (vz[k]),
      .x_o (vx[k+1]), .y_o (vy[k+1]), .z_o (vz[k+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sbv[k+1] <= '0;
      else        sbv[k+1] <= sbv[k];
    end
  end

  // distance scale by 1/K; bearing forced to zero for a zero offset
  logic [gpvc_pkg::DW-1:0]    dist_r;
  logic [31:0]                ang_r;
  gpvc_pkg::side_t            sbd_r;
  logic signed [gpvc_pkg::PW-1:0] dprod;

  assign dprod = gpvc_pkg::PW'(vx[N]) * gpvc_pkg::PW'(gpvc_pkg::INVK_Q20);

  always_ff @(posedge clk) begin
    dist_r <= dprod[gpvc_pkg::DW+19:20];
    ang_r  <= sbv[N].zero ? 32'h0 : vz[N];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sbd_r <= '0;
    else        sbd_r <= sbv[N];
  end

  // rotating start: heading error folded into +-pi/2, reached check
  logic signed [W-1:0]  rx [0:N];
  logic signed [W-1:0]  ry [0:N];
  logic signed [ZR-1:0] rz [0:N];
  gpvc_pkg::side_t      sbr [0:N];

  logic [31:0]          herr;
  logic signed [ZR-1:0] zs;
  logic signed [W-1:0]  dw;
  gpvc_pkg::side_t      sbp_nxt;

  always_comb begin
    herr = ang_r - {sbd_r.ph, 16'h0};
    zs   = ZR'(signed'(herr));
    dw   = W'(dist_r);
    sbp_nxt         = sbd_r;
    sbp_nxt.reached = sbd_r.hok &&
                      (dist_r < gpvc_pkg::DW'({pos_tol_r, 16'h0}));
  end

  always_ff @(posedge clk) begin
    ry[0] <= '0;
    if (zs > ZR'(32'sh4000_0000)) begin
      rz[0] <= zs - ZR'(33'sh0_8000_0000);
      rx[0] <= -dw;
    end else if (zs < -ZR'(32'sh4000_0000)) begin
      rz[0] <= zs + ZR'(33'sh0_8000_0000);
      rx[0] <= -dw;
    end else begin
      rz[0] <= zs;
      rx[0] <= dw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sbr[0] <= '0;
    else        sbr[0] <= sbp_nxt;
  end

  // rotating chain: resolve distance onto the heading error
  for (genvar k = 0; k < N; k++) begin : g_rot
    gpvc_cordic_stage #(.W(W), .WZ(ZR), .SHIFT(k), .VECTOR(1'b0)) u_stage (
      .clk (clk),
      .x_i (rx[k]), .y_i (ry[k]), .z_i (rz[k]),
      .x_o (rx[k+1]), .y_o (ry[k+1]), .z_o (rz[k+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sbr[k+1] <= '0;
      else        sbr[k+1] <= sbr[k];
    end
  end

  // velocity scale by 1/K with rounding
  localparam int QW = gpvc_pkg::PW + 1;
  logic signed [QW-1:0] px_r, py_r;
  gpvc_pkg::side_t      sbm_r;

  always_ff @(posedge clk) begin
    px_r <= QW'(rx[N]) * QW'(gpvc_pkg::INVK_Q20) + (QW'(1) <<< 34);
    py_r <= QW'(ry[N]) * QW'(gpvc_pkg::INVK_Q20) + (QW'(1) <<< 34);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sbm_r <= '0;
    else        sbm_r <= sbr[N];
  end

  // output: saturation, timeout override, status
  logic signed [QW-1:0] pxs, pys;
  gpvc_pkg::out_item_t  out_nxt;

  always_comb begin
    pxs = px_r >>> 35;
    pys = py_r >>> 35;
    if (sbm_r.tmo) begin
      out_nxt            = '0;
      out_nxt.nav_status = gpvc_pkg::ST_ABORTED;
    end else begin
      out_nxt.vel_x      = gpvc_pkg::sat16(pxs[30:0], lin_lim_r);
      out_nxt.vel_y      = gpvc_pkg::sat16(pys[30:0], lin_lim_r);
      out_nxt.yaw_rate   = sbm_r.om;
      out_nxt.nav_status = sbm_r.reached ? gpvc_pkg::ST_REACHED
                                         : gpvc_pkg::ST_RUNNING;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= sbm_r.valid;
  end

endmodule

### sv/gpvc_cordic_stage.sv
// one registered cordic micro-rotation, vectoring or rotating
module gpvc_cordic_stage #(
  parameter int W      = gpvc_pkg::CW,
  parameter int WZ     = 32,
  parameter int SHIFT  = 0,
  parameter bit VECTOR = 1'b1
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [WZ-1:0] z_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [WZ-1:0] z_o
);

  logic signed [W-1:0]  xs, ys, x_nxt, y_nxt;
  logic signed [WZ-1:0] aw, z_nxt;
  logic                 ccw;

  always_comb begin
    xs  = x_i >>> SHIFT;
    ys  = y_i >>> SHIFT;
    aw  = WZ'(gpvc_pkg::atan_ent(SHIFT));
    // vectoring drives y to zero, rotating drives z to zero
    ccw = VECTOR ? !(!y_i[W-1] && (y_i != '0)) : !z_i[WZ-1];
    if (ccw) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - aw;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + aw;
    end
  end

  always_ff @(posedge clk) begin
    x_o <= x_nxt;
    y_o <= y_nxt;
    z_o <= z_nxt;
  end

endmodule

### dv/tb.sv
// testbench of the go-to-goal pose controller: directed table, then random poses
`timescale 1ns / 100ps

module tb;

  // pose transfer to command transfer
  localparam int PIPE_DEPTH = 2 * 16 + 6;

  typedef struct {
    gpvc_pkg::in_item_t  pose;
    bit                  typed;
    gpvc_pkg::out_item_t cmd;
  } pose_row_t;

  // atan(2^-i) as a 32-bit binary angle, first sixteen micro-rotations
  localparam logic [31:0] ARCTAN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  gpvc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  gpvc_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_idx = '0;
  logic [31:0]         cfg_wdata = '0;

  // typed expectation riding along with the pose being driven
  bit                  row_typed = 1'b0;
  gpvc_pkg::out_item_t row_cmd = '0;

  // shadow copy of the goal, limits and tolerances
  logic signed [23:0] goal_x_q, goal_y_q;
  logic [15:0]        goal_h_q, pos_tol_q, head_tol_q;
  logic [14:0]        lin_lim_q, ang_lim_q;
  logic [31:0]        timeout_q;

  gpvc_pkg::out_item_t pending_cmds[$];
  pose_row_t           pose_rows[$];
  int        fail_count = 0;
  int        cmd_count = 0;
  int        abort_count = 0;
  int        reached_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  goto_pose_velocity_controller_core dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  function automatic longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // command expected for one pose under the current goal and limits
  function automatic gpvc_pkg::out_item_t steer_command(gpvc_pkg::in_item_t p);
    gpvc_pkg::out_item_t r;
    longint x, y, z, t, xs, ys, e;
    longint unsigned range_q16;
    logic [31:0] bearing, herr;
    logic signed [15:0] hdiff;
    r = '0;
    if (p.elapsed_ms > timeout_q) begin
      r.nav_status = gpvc_pkg::ST_ABORTED;
      return r;
    end
    x = (longint'(goal_x_q) - longint'(p.pose_x)) * 65536;
    y = (longint'(goal_y_q) - longint'(p.pose_y)) * 65536;
    // vectoring: range and bearing to the goal
    bearing = '0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x;
        y = -y;
        bearing = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; bearing = bearing + ARCTAN[i];
        end else begin
          x = x - ys; y = y + xs; bearing = bearing - ARCTAN[i];
        end
      end
    end else begin
      x = 0;
    end
    range_q16 = longint'(x * 636751) >>> 20;
    // rotating: resolve the range onto the heading error
    herr = bearing - {p.pose_heading, 16'h0000};
    z = longint'(signed'(herr));
    x = longint'(range_q16);
    y = 0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000; x = -x;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000; x = -x;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        t = x - ys; y = y + xs; z = z - longint'({32'h0, ARCTAN[i]});
      end else begin
        t = x + ys; y = y - xs; z = z + longint'({32'h0, ARCTAN[i]});
      end
      x = t;
    end
    r.vel_x = 16'(clip((x * 636751 + (64'sd1 <<< 34)) >>> 35, longint'(lin_lim_q)));
    r.vel_y = 16'(clip((y * 636751 + (64'sd1 <<< 34)) >>> 35, longint'(lin_lim_q)));
    // goal heading error wraps natively, pi comes out as -pi
    hdiff = signed'(goal_h_q - p.pose_heading);
    e = longint'(hdiff);
    r.yaw_rate = 16'(clip((e * 18850 + 32768) >>> 16, longint'(ang_lim_q)));
    r.nav_status = gpvc_pkg::ST_RUNNING;
    if (range_q16 < (longint'(pos_tol_q) << 16) &&
        (e < 0 ? -e : e) < longint'(head_tol_q))
      r.nav_status = gpvc_pkg::ST_REACHED;
    return r;
  endfunction

  // register writes, accepted poses and returned commands, all sampled at the edge
  always @(posedge clk) begin
    gpvc_pkg::out_item_t want;
    if (!rst_n) begin
      goal_x_q <= '0; goal_y_q <= '0; goal_h_q <= '0;
      lin_lim_q <= 15'd500; ang_lim_q <= 15'd1000;
      pos_tol_q <= 16'd20; head_tol_q <= 16'd182;
      timeout_q <= 32'd10000;
    end else begin
      if (out_valid) begin
        if (pending_cmds.size() == 0) begin
          $error("command transfer with nothing expected");
          fail_count++;
        end else begin
          want = pending_cmds.pop_front();
          cmd_count++;
          if (out_data.nav_status == gpvc_pkg::ST_ABORTED) abort_count++;
          if (out_data.nav_status == gpvc_pkg::ST_REACHED) reached_count++;
          if (out_data.vel_x !== want.vel_x) begin
            $error("vel_x expected %0d got %0d", want.vel_x, out_data.vel_x);
            fail_count++;
          end
          if (out_data.vel_y !== want.vel_y) begin
            $error("vel_y expected %0d got %0d", want.vel_y, out_data.vel_y);
            fail_count++;
          end
          if (out_data.yaw_rate !== want.yaw_rate) begin
            $error("yaw_rate expected %0d got %0d", want.yaw_rate, out_data.yaw_rate);
            fail_count++;
          end
          if (out_data.nav_status !== want.nav_status) begin
            $error("nav_status expected %0d got %0d", want.nav_status,
                   out_data.nav_status);
            fail_count++;
          end
        end
      end
      // prediction uses the settings in force when the pose is taken
      if (start && !busy)
        pending_cmds.push_back(row_typed ? row_cmd : steer_command(in_data));
      if (cfg_we) begin
        case (gpvc_pkg::reg_idx_t'(cfg_idx))
          gpvc_pkg::REG_GOAL_X:        goal_x_q   <= cfg_wdata[23:0];
          gpvc_pkg::REG_GOAL_Y:        goal_y_q   <= cfg_wdata[23:0];
          gpvc_pkg::REG_GOAL_HEADING:  goal_h_q   <= cfg_wdata[15:0];
          gpvc_pkg::REG_LINEAR_LIMIT:  lin_lim_q  <= cfg_wdata[14:0];
          gpvc_pkg::REG_ANGULAR_LIMIT: ang_lim_q  <= cfg_wdata[14:0];
          gpvc_pkg::REG_POS_TOL:       pos_tol_q  <= cfg_wdata[15:0];
          gpvc_pkg::REG_HEAD_TOL:      head_tol_q <= cfg_wdata[15:0];
          gpvc_pkg::REG_TIMEOUT:       timeout_q  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(gpvc_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop sending and let the pipeline run dry before touching registers
  task automatic drain();
    start <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one pose transfer; start stays high if the next call follows directly
  task automatic send_pose(gpvc_pkg::in_item_t p, bit typed, gpvc_pkg::out_item_t cmd);
    start <= 1'b1;
    in_data <= p;
    row_typed <= typed;
    row_cmd <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic add_row(logic signed [23:0] px, logic signed [23:0] py,
                         logic signed [15:0] ph, logic [31:0] el,
                         bit typed, gpvc_pkg::out_item_t cmd);
    pose_row_t r;
    r.pose = '{pose_x: px, pose_y: py, pose_heading: ph, elapsed_ms: el};
    r.typed = typed;
    r.cmd = cmd;
    pose_rows.push_back(r);
  endtask

  task automatic run_rows();
    @(posedge clk);
    while (pose_rows.size() != 0) begin
      pose_row_t r;
      r = pose_rows.pop_front();
      send_pose(r.pose, r.typed, r.cmd);
    end
    drain();
  endtask

  function automatic gpvc_pkg::in_item_t random_pose();
    gpvc_pkg::in_item_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.pose_x = $urandom;
    p.pose_y = $urandom;
    p.pose_heading = $urandom;
    p.elapsed_ms = $urandom_range(0, timeout_q);
    case (mode)
      0: p.elapsed_ms = $urandom;   // noise across every bit
      1, 2: begin                   // close to the goal, reached or nearly
        p.pose_x = goal_x_q + 24'(signed'($urandom_range(0, 60)) - 30);
        p.pose_y = goal_y_q + 24'(signed'($urandom_range(0, 60)) - 30);
        p.pose_heading = goal_h_q + 16'(signed'($urandom_range(0, 600)) - 300);
      end
      3: begin                      // past the timeout
        if (timeout_q != 32'hFFFFFFFF)
          p.elapsed_ms = $urandom_range(timeout_q + 1, 32'hFFFFFFFF);
      end
      4: ;                          // anywhere on the map
      default: begin                // the usual approach from within 100000 mm on each axis
        p.pose_x = goal_x_q + 24'(signed'($urandom_range(0, 200000)) - 100000);
        p.pose_y = goal_y_q + 24'(signed'($urandom_range(0, 200000)) - 100000);
      end
    endcase
    return p;
  endfunction

  task automatic random_settings();
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    write_reg(gpvc_pkg::REG_GOAL_X,
              wide ? $urandom : 32'(signed'($urandom_range(0, 20000)) - 10000));
    write_reg(gpvc_pkg::REG_GOAL_Y,
              wide ? $urandom : 32'(signed'($urandom_range(0, 20000)) - 10000));
    write_reg(gpvc_pkg::REG_GOAL_HEADING, $urandom);
    write_reg(gpvc_pkg::REG_LINEAR_LIMIT, wide ? $urandom : $urandom_range(0, 3000));
    write_reg(gpvc_pkg::REG_ANGULAR_LIMIT, wide ? $urandom : $urandom_range(0, 5000));
    write_reg(gpvc_pkg::REG_POS_TOL, wide ? $urandom : $urandom_range(0, 100));
    write_reg(gpvc_pkg::REG_HEAD_TOL,
              wide ? $urandom_range(0, 32768) : $urandom_range(0, 1000));
    write_reg(gpvc_pkg::REG_TIMEOUT, $urandom);
  endtask

  initial begin
    gpvc_pkg::out_item_t none, abort_cmd, still_cmd;
    none = '0;
    abort_cmd = '0;
    abort_cmd.nav_status = gpvc_pkg::ST_ABORTED;
    still_cmd = '0;
    still_cmd.nav_status = gpvc_pkg::ST_REACHED;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // defaults after reset
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd10001, 1'b1, abort_cmd);
    add_row(24'sd0, 24'sd0, 16'sd0, 32'hFFFFFFFF, 1'b1, abort_cmd);
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd0, 1'b1, still_cmd);   // zero offset
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd10000, 1'b1, still_cmd);
    add_row(-24'sd8388608, 24'sd8388607, 16'sd32767, 32'd5, 1'b0, none);
    add_row(24'sd8388607, -24'sd8388608, -16'sd32768, 32'd9999, 1'b0, none);
    add_row(24'sd0, 24'sd0, -16'sd32768, 32'd0, 1'b0, none);  // heading error pi
    add_row(-24'sd1000, 24'sd0, 16'sd16384, 32'd1, 1'b0, none);
    add_row(24'sd10, 24'sd10, 16'sd100, 32'd1, 1'b0, none);
    run_rows();

    // upper extremes everywhere, but goal y at its most negative value
    write_reg(gpvc_pkg::REG_GOAL_X, 32'h007FFFFF);
    write_reg(gpvc_pkg::REG_GOAL_Y, 32'h00800000);
    write_reg(gpvc_pkg::REG_GOAL_HEADING, 32'h00007FFF);
    write_reg(gpvc_pkg::REG_LINEAR_LIMIT, 32'h7FFF);
    write_reg(gpvc_pkg::REG_ANGULAR_LIMIT, 32'h7FFF);
    write_reg(gpvc_pkg::REG_POS_TOL, 32'hFFFF);
    write_reg(gpvc_pkg::REG_HEAD_TOL, 32'h8000);
    write_reg(gpvc_pkg::REG_TIMEOUT, 32'hFFFFFFFF);
    add_row(-24'sd8388608, 24'sd8388607, -16'sd32768, 32'hFFFFFFFF, 1'b0, none);
    add_row(24'sd8388607, -24'sd8388608, 16'sd32767, 32'd0, 1'b0, none);
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd0, 1'b0, none);
    add_row(24'sd8388000, -24'sd8388000, 16'sd0, 32'd7, 1'b0, none);
    run_rows();

    // lower extremes: no speed allowed, nothing counts as reached
    write_reg(gpvc_pkg::REG_GOAL_X, 32'h0);
    write_reg(gpvc_pkg::REG_GOAL_Y, 32'h0);
    write_reg(gpvc_pkg::REG_GOAL_HEADING, 32'h0);
    write_reg(gpvc_pkg::REG_LINEAR_LIMIT, 32'h0);
    write_reg(gpvc_pkg::REG_ANGULAR_LIMIT, 32'h0);
    write_reg(gpvc_pkg::REG_POS_TOL, 32'h0);
    write_reg(gpvc_pkg::REG_HEAD_TOL, 32'h0);
    write_reg(gpvc_pkg::REG_TIMEOUT, 32'h0);
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd0, 1'b1, none);
    add_row(24'sd5000, -24'sd5000, 16'sd9000, 32'd0, 1'b1, none);
    add_row(24'sd0, 24'sd0, 16'sd0, 32'd1, 1'b1, abort_cmd);
    run_rows();

    // random phases, new settings between them once the pipeline is empty
    for (int phase = 0; phase < 6; phase++) begin
      int sent;
      random_settings();
      sent = 0;
      @(posedge clk);
      while (sent < 300) begin
        int burst, gap;
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < 300; k++) begin
          send_pose(random_pose(), 1'b0, none);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drain();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    $display("covered %0d command transfers, %0d aborted and %0d reached,",
             cmd_count, abort_count, reached_count);
    $display("over reset defaults, both register extremes and six random settings");
    if (fail_count == 0 && pending_cmds.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
